/* rtl/bp3d_pkg.sv */
`timescale 1ns / 1ps

package bp3d_pkg;

  // coordinate width and default store depths
  localparam int COORD_BITS     = 10;
  localparam int DEF_MAX_FREE   = 64;
  localparam int DEF_MAX_PLACED = 64;
  localparam int RATIO_BITS     = 9;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_DEPTH     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALLOW_FLIP    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUPPORT_RATIO = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // request modes
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   wide_t;

  localparam coord_t CMAX = '1;

  typedef struct packed {
    logic   mode;
    coord_t box_width;
    coord_t box_height;
    coord_t box_depth;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
    coord_t     placed_width;
    coord_t     placed_height;
    coord_t     placed_depth;
    logic       rotated;
  } res_t;

  // one free box; dead marks an entry removed by pruning
  typedef struct packed {
    logic   dead;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t ex;
    coord_t ey;
    coord_t ez;
    coord_t slx;
    coord_t shx;
    coord_t sly;
    coord_t shy;
  } free_ent_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
    coord_t h;
    coord_t d;
  } placed_ent_t;

  function automatic wide_t ext(input coord_t v);
    return {1'b0, v};
  endfunction

  // clamp to the largest coordinate
  function automatic coord_t sat(input wide_t v);
    return (v > ext(CMAX)) ? CMAX : v[COORD_BITS-1:0];
  endfunction

  // sort key: y, then z, then x
  function automatic logic [3*COORD_BITS-1:0] key(input free_ent_t e);
    return {e.cy, e.cz, e.cx};
  endfunction

  // box a lies inside box b
  function automatic logic contained(input free_ent_t a, input free_ent_t b);
    return (a.cx >= b.cx) && (a.cy >= b.cy) && (a.cz >= b.cz) &&
           (ext(a.cx) + ext(a.ex) <= ext(b.cx) + ext(b.ex)) &&
           (ext(a.cy) + ext(a.ey) <= ext(b.cy) + ext(b.ey)) &&
           (ext(a.cz) + ext(a.ez) <= ext(b.cz) + ext(b.ez));
  endfunction

endpackage

/* rtl/box_packer_3d_free_space.sv */
`timescale 1ns / 1ps

// Packs boxes into a bin, keeping free space as maximal free boxes in one
// on-chip memory and placed boxes in another. Pulse start while busy is low;
// the result word appears on result for exactly one cycle with done high and
// cannot be held off, so the receiver must take it then. A restart answers in the
// cycle after it is taken. An insert runs a stable insertion sort of the free
// boxes, a fit scan against the placed store, split and append, then prune and
// compaction, all of which share the single read port of the free-box memory.
// Before the first restart every insert answers no fit.
module box_packer_3d_free_space #(
  parameter int MAX_FREE   = bp3d_pkg::DEF_MAX_FREE,
  parameter int MAX_PLACED = bp3d_pkg::DEF_MAX_PLACED
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  bp3d_pkg::req_t                     request,
  output logic                               done,
  output bp3d_pkg::res_t                     result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bp3d_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bp3d_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import bp3d_pkg::*;

  localparam int FCW = $clog2(MAX_FREE + 1);
  localparam int FA  = $clog2(2 * MAX_FREE);
  localparam int PCW = $clog2(MAX_PLACED + 1);
  localparam int PA  = $clog2(MAX_PLACED);
  localparam int PW  = COORD_BITS + RATIO_BITS;

  localparam logic [FCW-1:0] FREE_LIMIT   = FCW'(MAX_FREE);
  localparam logic [PCW-1:0] PLACED_LIMIT = PCW'(MAX_PLACED);
  localparam logic [FA-1:0]  B_BASE       = FA'(MAX_FREE);
  localparam logic [2:0]     LAST_PIECE   = 3'd5;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SO_RD  = 5'd1;
  localparam logic [4:0] S_SO_KEY = 5'd2;
  localparam logic [4:0] S_SO_CMP = 5'd3;
  localparam logic [4:0] S_SO_PUT = 5'd4;
  localparam logic [4:0] S_SC_RD  = 5'd5;
  localparam logic [4:0] S_SC_GET = 5'd6;
  localparam logic [4:0] S_SC_TRY = 5'd7;
  localparam logic [4:0] S_SC_BLK = 5'd8;
  localparam logic [4:0] S_SC_HIT = 5'd9;
  localparam logic [4:0] S_SP_RD  = 5'd10;
  localparam logic [4:0] S_SP_CHK = 5'd11;
  localparam logic [4:0] S_SP_PC  = 5'd12;
  localparam logic [4:0] S_AP_RD  = 5'd13;
  localparam logic [4:0] S_AP_WR  = 5'd14;
  localparam logic [4:0] S_PR_RD  = 5'd15;
  localparam logic [4:0] S_PR_GET = 5'd16;
  localparam logic [4:0] S_PR_CMP = 5'd17;
  localparam logic [4:0] S_CP_RD  = 5'd18;
  localparam logic [4:0] S_CP_WR  = 5'd19;
  localparam logic [4:0] S_FIN    = 5'd20;

  // control registers
  logic [4:0]      state, state_next;
  logic [FCW-1:0]  fcount, fcount_next;
  logic [PCW-1:0]  pcount, pcount_next;
  logic            done_next;
  coord_t          bin_w, bin_h, bin_d;
  logic            allow_flip;
  logic [RATIO_BITS-1:0] ratio;

  // working registers
  logic [FCW-1:0]  idx_i, idx_i_next;
  logic [FCW-1:0]  idx_j, idx_j_next;
  logic [FCW-1:0]  wr_s, wr_s_next;
  logic [FCW-1:0]  pcs, pcs_next;
  logic [FCW-1:0]  live, live_next;
  logic [PCW-1:0]  pj, pj_next;
  logic [2:0]      pc, pc_next;
  logic            flip, flip_next;
  logic            dropped, dropped_next;
  free_ent_t       cur, cur_next;
  coord_t          req_w, req_w_next, req_h, req_h_next, req_d, req_d_next;
  coord_t          px, px_next, py, py_next, pz, pz_next;
  res_t            result_next;

  // memory ports
  free_ent_t       fmem [2*MAX_FREE];
  logic            fre_we;
  logic [FA-1:0]   fre_waddr, fre_raddr;
  free_ent_t       fre_wdata, fre_rdata;
  placed_ent_t     pmem [MAX_PLACED];
  logic            pl_we;
  logic [PA-1:0]   pl_waddr, pl_raddr;
  placed_ent_t     pl_wdata, pl_rdata;

  // evaluation logic
  coord_t          try_w, try_h;
  logic [PW-1:0]   prod_w, prod_h;
  logic            fit_ok, sup_ok, blocked, overlap;
  wide_t           fxe, fye, fze, pxw, pyh, pzd;
  free_ent_t       piece;
  logic            pcond;
  logic            push;
  logic            stop;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // orientation under test
  assign try_w = flip ? req_h : req_w;
  assign try_h = flip ? req_w : req_h;

  // size and support tests on the held free box
  assign prod_w = PW'(try_w) * PW'(ratio);
  assign prod_h = PW'(try_h) * PW'(ratio);
  assign fit_ok = (cur.ex >= try_w) && (cur.ey >= try_h) && (cur.ez >= req_d);
  assign sup_ok = (cur.shx >= cur.slx) && (cur.shy >= cur.sly) &&
                  ({1'b0, cur.shx - cur.slx, 8'b0} >= prod_w) &&
                  ({1'b0, cur.shy - cur.sly, 8'b0} >= prod_h);

  // placed box lying over the candidate spot
  assign blocked = (ext(cur.slx) < ext(pl_rdata.x) + ext(pl_rdata.w)) &&
                   (ext(pl_rdata.x) < ext(cur.slx) + ext(try_w)) &&
                   (ext(cur.sly) < ext(pl_rdata.y) + ext(pl_rdata.h)) &&
                   (ext(pl_rdata.y) < ext(cur.sly) + ext(try_h)) &&
                   (ext(cur.cz) < ext(pl_rdata.z) + ext(pl_rdata.d));

  // placed box extents
  assign pxw = ext(px) + ext(try_w);
  assign pyh = ext(py) + ext(try_h);
  assign pzd = ext(pz) + ext(req_d);

  // overlap of the placed box with the free box just read
  assign overlap = !((ext(px) >= ext(fre_rdata.cx) + ext(fre_rdata.ex)) ||
                     (pxw <= ext(fre_rdata.cx)) ||
                     (ext(py) >= ext(fre_rdata.cy) + ext(fre_rdata.ey)) ||
                     (pyh <= ext(fre_rdata.cy)) ||
                     (ext(pz) >= ext(fre_rdata.cz) + ext(fre_rdata.ez)) ||
                     (pzd <= ext(fre_rdata.cz)));

  // far faces of the free box being split
  assign fxe = ext(cur.cx) + ext(cur.ex);
  assign fye = ext(cur.cy) + ext(cur.ey);
  assign fze = ext(cur.cz) + ext(cur.ez);

  // one of the six split pieces, chosen by pc
  always_comb begin
    piece = cur;
    piece.dead = 1'b0;
    pcond = 1'b0;
    case (pc)
      3'd0: begin
        pcond = (py > cur.cy) && (ext(py) < fye);
        piece.ey = py - cur.cy;
        piece.shy = (cur.shy < py) ? cur.shy : py;
      end
      3'd1: begin
        pcond = (pyh < fye);
        piece.cy = sat(pyh);
        piece.ey = sat(fye - pyh);
        piece.sly = sat((ext(cur.sly) > pyh) ? ext(cur.sly) : pyh);
      end
      3'd2: begin
        pcond = (px > cur.cx) && (ext(px) < fxe);
        piece.ex = px - cur.cx;
        piece.shx = (cur.shx < px) ? cur.shx : px;
      end
      3'd3: begin
        pcond = (pxw < fxe);
        piece.cx = sat(pxw);
        piece.ex = sat(fxe - pxw);
        piece.slx = sat((ext(cur.slx) > pxw) ? ext(cur.slx) : pxw);
      end
      3'd4: begin
        pcond = (pz > cur.cz) && (ext(pz) < fze);
        piece.ez = pz - cur.cz;
      end
      3'd5: begin
        pcond = (pzd < fze);
        piece.cz = sat(pzd);
        piece.ez = sat(fze - pzd);
        piece.slx = px;
        piece.shx = sat(pxw);
        piece.sly = py;
        piece.shy = sat(pyh);
      end
      default: begin
        pcond = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next   = state;
    fcount_next  = fcount;
    pcount_next  = pcount;
    done_next    = 1'b0;
    idx_i_next   = idx_i;
    idx_j_next   = idx_j;
    wr_s_next    = wr_s;
    pcs_next     = pcs;
    live_next    = live;
    pj_next      = pj;
    pc_next      = pc;
    flip_next    = flip;
    dropped_next = dropped;
    cur_next     = cur;
    req_w_next   = req_w;
    req_h_next   = req_h;
    req_d_next   = req_d;
    px_next      = px;
    py_next      = py;
    pz_next      = pz;
    result_next  = result;
    fre_we       = 1'b0;
    fre_waddr    = '0;
    fre_wdata    = cur;
    fre_raddr    = '0;
    pl_we        = 1'b0;
    pl_waddr     = '0;
    pl_wdata     = '0;
    pl_raddr     = '0;
    push         = 1'b0;
    stop         = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (request.mode == MODE_RESTART) begin
            fre_we    = 1'b1;
            fre_waddr = '0;
            fre_wdata = '{dead: 1'b0, cx: '0, cy: '0, cz: '0, ex: bin_w, ey: bin_h,
                          ez: bin_d, slx: '0, shx: bin_w, sly: '0, shy: bin_h};
            fcount_next = FCW'(1);
            pcount_next = '0;
            result_next = '0;
            result_next.status = ST_OK;
            done_next = 1'b1;
          end else begin
            req_w_next = request.box_width;
            req_h_next = request.box_height;
            req_d_next = request.box_depth;
            idx_i_next = FCW'(1);
            state_next = S_SO_RD;
          end
        end
      end

      // stable insertion sort on (y, z, x)
      S_SO_RD: begin
        if (idx_i >= fcount) begin
          idx_i_next = '0;
          state_next = S_SC_RD;
        end else begin
          fre_raddr  = FA'(idx_i);
          state_next = S_SO_KEY;
        end
      end
      S_SO_KEY: begin
        cur_next   = fre_rdata;
        idx_j_next = idx_i;
        fre_raddr  = FA'(idx_i - FCW'(1));
        state_next = S_SO_CMP;
      end
      S_SO_CMP: begin
        if (key(fre_rdata) > key(cur)) begin
          fre_we     = 1'b1;
          fre_waddr  = FA'(idx_j);
          fre_wdata  = fre_rdata;
          idx_j_next = idx_j - FCW'(1);
          if (idx_j == FCW'(1)) begin
            state_next = S_SO_PUT;
          end else begin
            fre_raddr = FA'(idx_j - FCW'(2));
          end
        end else begin
          fre_we     = 1'b1;
          fre_waddr  = FA'(idx_j);
          fre_wdata  = cur;
          idx_i_next = idx_i + FCW'(1);
          state_next = S_SO_RD;
        end
      end
      S_SO_PUT: begin
        fre_we     = 1'b1;
        fre_waddr  = '0;
        fre_wdata  = cur;
        idx_i_next = idx_i + FCW'(1);
        state_next = S_SO_RD;
      end

      // first fitting free box in sorted order
      S_SC_RD: begin
        if (idx_i >= fcount) begin
          result_next = '0;
          result_next.status = ST_NO_FIT;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          fre_raddr  = FA'(idx_i);
          state_next = S_SC_GET;
        end
      end
      S_SC_GET: begin
        cur_next   = fre_rdata;
        flip_next  = 1'b0;
        state_next = S_SC_TRY;
      end
      S_SC_TRY: begin
        if (fit_ok && sup_ok) begin
          if (pcount == '0) begin
            state_next = S_SC_HIT;
          end else begin
            pj_next    = '0;
            pl_raddr   = '0;
            state_next = S_SC_BLK;
          end
        end else if (!flip && allow_flip) begin
          flip_next = 1'b1;
        end else begin
          idx_i_next = idx_i + FCW'(1);
          state_next = S_SC_RD;
        end
      end
      S_SC_BLK: begin
        if (blocked) begin
          if (!flip && allow_flip) begin
            flip_next  = 1'b1;
            state_next = S_SC_TRY;
          end else begin
            idx_i_next = idx_i + FCW'(1);
            state_next = S_SC_RD;
          end
        end else if (pj + PCW'(1) < pcount) begin
          pj_next  = pj + PCW'(1);
          pl_raddr = PA'(pj + PCW'(1));
        end else begin
          state_next = S_SC_HIT;
        end
      end
      S_SC_HIT: begin
        if (try_h == '0) begin
          result_next = '0;
          result_next.status = ST_NO_FIT;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          px_next      = cur.slx;
          py_next      = cur.sly;
          pz_next      = cur.cz;
          idx_i_next   = '0;
          wr_s_next    = '0;
          pcs_next     = '0;
          live_next    = fcount;
          dropped_next = 1'b0;
          state_next   = S_SP_RD;
        end
      end

      // split: survivors compact in place, pieces go to the upper half
      S_SP_RD: begin
        if (idx_i >= fcount) begin
          idx_j_next = '0;
          state_next = S_AP_RD;
        end else begin
          fre_raddr  = FA'(idx_i);
          state_next = S_SP_CHK;
        end
      end
      S_SP_CHK: begin
        if (!overlap) begin
          fre_we     = 1'b1;
          fre_waddr  = FA'(wr_s);
          fre_wdata  = fre_rdata;
          wr_s_next  = wr_s + FCW'(1);
          idx_i_next = idx_i + FCW'(1);
          state_next = S_SP_RD;
        end else begin
          cur_next   = fre_rdata;
          pc_next    = '0;
          state_next = S_SP_PC;
        end
      end
      S_SP_PC: begin
        if (pcond) begin
          if (live < FREE_LIMIT) begin
            fre_we    = 1'b1;
            fre_waddr = B_BASE + FA'(pcs);
            fre_wdata = piece;
            pcs_next  = pcs + FCW'(1);
            push      = 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
        end
        if (pc == LAST_PIECE) begin
          live_next  = live + FCW'(push) - FCW'(1);
          idx_i_next = idx_i + FCW'(1);
          state_next = S_SP_RD;
        end else begin
          live_next = live + FCW'(push);
          pc_next   = pc + 3'd1;
        end
      end

      // append pieces after the survivors
      S_AP_RD: begin
        if (idx_j >= pcs) begin
          fcount_next = wr_s;
          idx_i_next  = '0;
          state_next  = S_PR_RD;
        end else begin
          fre_raddr  = B_BASE + FA'(idx_j);
          state_next = S_AP_WR;
        end
      end
      S_AP_WR: begin
        fre_we     = 1'b1;
        fre_waddr  = FA'(wr_s);
        fre_wdata  = fre_rdata;
        wr_s_next  = wr_s + FCW'(1);
        idx_j_next = idx_j + FCW'(1);
        state_next = S_AP_RD;
      end

      // prune contained boxes by marking them dead
      S_PR_RD: begin
        if (idx_i >= fcount) begin
          idx_i_next = '0;
          wr_s_next  = '0;
          state_next = S_CP_RD;
        end else begin
          fre_raddr  = FA'(idx_i);
          state_next = S_PR_GET;
        end
      end
      S_PR_GET: begin
        cur_next = fre_rdata;
        if (fre_rdata.dead || (idx_i + FCW'(1) >= fcount)) begin
          idx_i_next = idx_i + FCW'(1);
          state_next = S_PR_RD;
        end else begin
          idx_j_next = idx_i + FCW'(1);
          fre_raddr  = FA'(idx_i + FCW'(1));
          state_next = S_PR_CMP;
        end
      end
      S_PR_CMP: begin
        if (!fre_rdata.dead) begin
          if (contained(cur, fre_rdata)) begin
            fre_we    = 1'b1;
            fre_waddr = FA'(idx_i);
            fre_wdata = cur;
            fre_wdata.dead = 1'b1;
            stop      = 1'b1;
          end else if (contained(fre_rdata, cur)) begin
            fre_we    = 1'b1;
            fre_waddr = FA'(idx_j);
            fre_wdata = fre_rdata;
            fre_wdata.dead = 1'b1;
          end
        end
        if (stop || (idx_j + FCW'(1) >= fcount)) begin
          idx_i_next = idx_i + FCW'(1);
          state_next = S_PR_RD;
        end else begin
          idx_j_next = idx_j + FCW'(1);
          fre_raddr  = FA'(idx_j + FCW'(1));
        end
      end

      // squeeze out dead entries
      S_CP_RD: begin
        if (idx_i >= fcount) begin
          fcount_next = wr_s;
          state_next  = S_FIN;
        end else begin
          fre_raddr  = FA'(idx_i);
          state_next = S_CP_WR;
        end
      end
      S_CP_WR: begin
        if (!fre_rdata.dead) begin
          fre_we    = 1'b1;
          fre_waddr = FA'(wr_s);
          fre_wdata = fre_rdata;
          wr_s_next = wr_s + FCW'(1);
        end
        idx_i_next = idx_i + FCW'(1);
        state_next = S_CP_RD;
      end

      // record the placed box if the placed store has room, and report
      S_FIN: begin
        result_next.status        = dropped ? ST_DROPPED : ST_OK;
        result_next.pos_x         = px;
        result_next.pos_y         = py;
        result_next.pos_z         = pz;
        result_next.placed_width  = try_w;
        result_next.placed_height = try_h;
        result_next.placed_depth  = req_d;
        result_next.rotated       = flip;
        if (pcount >= PLACED_LIMIT) begin
          result_next.status = ST_FULL;
        end else begin
          pl_we       = 1'b1;
          pl_waddr    = PA'(pcount);
          pl_wdata    = '{x: px, y: py, z: pz, w: try_w, h: try_h, d: req_d};
          pcount_next = pcount + PCW'(1);
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fcount     <= '0;
      pcount     <= '0;
      done       <= 1'b0;
      bin_w      <= CMAX;
      bin_h      <= CMAX;
      bin_d      <= CMAX;
      allow_flip <= 1'b0;
      ratio      <= '0;
    end else begin
      state  <= state_next;
      fcount <= fcount_next;
      pcount <= pcount_next;
      done   <= done_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BIN_WIDTH:     bin_w      <= cfg_data[COORD_BITS-1:0];
          REG_BIN_HEIGHT:    bin_h      <= cfg_data[COORD_BITS-1:0];
          REG_BIN_DEPTH:     bin_d      <= cfg_data[COORD_BITS-1:0];
          REG_ALLOW_FLIP:    allow_flip <= cfg_data[0];
          REG_SUPPORT_RATIO: ratio      <= cfg_data[RATIO_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_i   <= idx_i_next;
    idx_j   <= idx_j_next;
    wr_s    <= wr_s_next;
    pcs     <= pcs_next;
    live    <= live_next;
    pj      <= pj_next;
    pc      <= pc_next;
    flip    <= flip_next;
    dropped <= dropped_next;
    cur     <= cur_next;
    req_w   <= req_w_next;
    req_h   <= req_h_next;
    req_d   <= req_d_next;
    px      <= px_next;
    py      <= py_next;
    pz      <= pz_next;
    result  <= result_next;
  end

  // free-box memory
  always_ff @(posedge clk) begin
    if (fre_we) begin
      fmem[fre_waddr] <= fre_wdata;
    end
    fre_rdata <= fmem[fre_raddr];
  end

  // placed-box memory
  always_ff @(posedge clk) begin
    if (pl_we) begin
      pmem[pl_waddr] <= pl_wdata;
    end
    pl_rdata <= pmem[pl_raddr];
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");
  a_free_bound: assert property (@(posedge clk) disable iff (rst) fcount <= FREE_LIMIT)
    else $error("free count past store depth");
  a_placed_bound: assert property (@(posedge clk) disable iff (rst) pcount <= PLACED_LIMIT)
    else $error("placed count past store depth");
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request taken but neither working nor answered");
  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_NO_FIT) |-> (result.pos_x == '0 &&
      result.placed_height == '0 && result.rotated == 1'b0))
    else $error("no-fit word carries a position");

endmodule
